/* rtl/cds_pkg.sv */
// shared types and constants of the 4:4:4 to 4:2:0 chroma downsampler
// no dependencies; used by cds_front, cds_avg and the top level
`default_nettype none
package cds_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int SAMPLE_BITS     = 16;
  localparam int FIELD_BITS      = 16;
  localparam int LW_BITS         = 13;
  localparam int LINE_DEPTH      = MAX_WIDTH / 2;
  localparam int COL_BITS        = $clog2(MAX_WIDTH);
  localparam int IDX_BITS        = $clog2(LINE_DEPTH);
  localparam int PAIR_BITS       = SAMPLE_BITS + 1;
  localparam int SUM_BITS        = PAIR_BITS + 1;
  localparam int LINE_WORD_BITS  = 2 * PAIR_BITS;
  localparam int CMP_BITS        = (LW_BITS > COL_BITS + 1) ? LW_BITS : COL_BITS + 1;
  localparam int TDATA_BITS      = ((3 * FIELD_BITS + 7) / 8) * 8;
  localparam logic [LW_BITS-1:0] LINE_WIDTH_RESET = LW_BITS'(1920);

  // work handed from the front end to the averaging stage
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] luma;
    logic                   emit;
    logic [PAIR_BITS-1:0]   cb_pair;
    logic [PAIR_BITS-1:0]   cr_pair;
  } cds_stage_t;

  // line store access for one item
  typedef struct packed {
    logic                      we;
    logic [IDX_BITS-1:0]       waddr;
    logic [LINE_WORD_BITS-1:0] wdata;
    logic                      re;
    logic [IDX_BITS-1:0]       raddr;
  } cds_line_cmd_t;

endpackage
`default_nettype wire

/* rtl/cds_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module cds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/cds_front.sv */
// front end: raster position, horizontal pair sums and line store commands
// depends on cds_pkg
`default_nettype none
module cds_front import cds_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [LW_BITS-1:0]     cfg_wr_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [TDATA_BITS-1:0]  in_tdata,
  input  wire logic                   in_tuser,
  output logic                        stage_valid,
  input  wire logic                   stage_ready,
  output cds_stage_t                  stage,
  output cds_line_cmd_t               line_cmd
);

  logic [LW_BITS-1:0]     line_width_r;
  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic                   odd_r, odd_nxt;
  logic [PAIR_BITS-1:0]   cb_part_r, cr_part_r;
  logic                   stage_valid_r;
  cds_stage_t             stage_r, stage_nxt;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] luma, cb, cr;
  logic [COL_BITS-1:0]    col;
  logic                   odd;
  logic [PAIR_BITS-1:0]   cb_pair, cr_pair;
  logic [CMP_BITS-1:0]    w_even, eff_w, col_inc;

  assign in_tready   = !stage_valid_r || stage_ready;
  assign accept      = in_tvalid && in_tready;
  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;

  assign luma = in_tdata[SAMPLE_BITS-1:0];
  assign cb   = in_tdata[FIELD_BITS +: SAMPLE_BITS];
  assign cr   = in_tdata[2*FIELD_BITS +: SAMPLE_BITS];

  always_comb begin
    w_even = CMP_BITS'(line_width_r) & ~CMP_BITS'(1);
    if (w_even < CMP_BITS'(2)) begin
      eff_w = CMP_BITS'(2);
    end else if (w_even > CMP_BITS'(MAX_WIDTH)) begin
      eff_w = CMP_BITS'(MAX_WIDTH) & ~CMP_BITS'(1);
    end else begin
      eff_w = w_even;
    end
  end

  always_comb begin
    col     = in_tuser ? '0 : col_r;
    odd     = in_tuser ? 1'b0 : odd_r;
    cb_pair = cb_part_r + PAIR_BITS'(cb);
    cr_pair = cr_part_r + PAIR_BITS'(cr);
    col_inc = CMP_BITS'(col) + CMP_BITS'(1);
    // a width lowered mid-row ends the row after this pixel
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      odd_nxt = !odd;
    end else begin
      col_nxt = col_inc[COL_BITS-1:0];
      odd_nxt = odd;
    end

    stage_nxt.luma    = luma;
    stage_nxt.emit    = col[0] && odd;
    stage_nxt.cb_pair = cb_pair;
    stage_nxt.cr_pair = cr_pair;

    line_cmd.we    = accept && col[0] && !odd;
    line_cmd.re    = accept && col[0] && odd;
    line_cmd.waddr = col[COL_BITS-1:1];
    line_cmd.raddr = col[COL_BITS-1:1];
    line_cmd.wdata = {cr_pair, cb_pair};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= LINE_WIDTH_RESET;
      col_r         <= '0;
      odd_r         <= 1'b0;
      cb_part_r     <= '0;
      cr_part_r     <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_width_r <= cfg_wr_data;
      end
      if (accept) begin
        col_r         <= col_nxt;
        odd_r         <= odd_nxt;
        stage_valid_r <= 1'b1;
        if (!col[0]) begin
          cb_part_r <= PAIR_BITS'(cb);
          cr_part_r <= PAIR_BITS'(cr);
        end
      end else if (stage_ready) begin
        stage_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/cds_avg.sv */
// averaging stage: adds the stored pair sums and holds the output item
// depends on cds_pkg
`default_nettype none
module cds_avg import cds_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      stage_valid,
  output logic                           stage_ready,
  input  wire cds_stage_t                stage,
  input  wire logic [LINE_WORD_BITS-1:0] line_rdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [TDATA_BITS-1:0]          out_tdata,
  output logic                           out_tuser
);

  logic                   out_valid_r;
  logic [TDATA_BITS-1:0]  out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  logic                   go;
  logic [SUM_BITS-1:0]    cb_sum, cr_sum;
  logic [SAMPLE_BITS-1:0] cb_avg, cr_avg;

  assign stage_ready = !out_valid_r || out_tready;
  assign go          = stage_valid && stage_ready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign out_tuser   = out_user_r;

  always_comb begin
    cb_sum = SUM_BITS'(line_rdata[PAIR_BITS-1:0]) + SUM_BITS'(stage.cb_pair) + SUM_BITS'(2);
    cr_sum = SUM_BITS'(line_rdata[LINE_WORD_BITS-1:PAIR_BITS]) + SUM_BITS'(stage.cr_pair)
           + SUM_BITS'(2);
    cb_avg = stage.emit ? cb_sum[SUM_BITS-1:2] : '0;
    cr_avg = stage.emit ? cr_sum[SUM_BITS-1:2] : '0;
    out_data_nxt = '0;
    out_data_nxt[FIELD_BITS-1:0]            = FIELD_BITS'(stage.luma);
    out_data_nxt[FIELD_BITS +: FIELD_BITS]   = FIELD_BITS'(cb_avg);
    out_data_nxt[2*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(cr_avg);
    out_user_nxt = stage.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/chroma_444_to_420_box_downsampler.sv */
// top level of the 4:4:4 to 4:2:0 chroma downsampler with 2x2 box averaging
// depends on cds_pkg, cds_ram, cds_front, cds_avg
//
// usage:
//   in_*  : one 4:4:4 pixel per item in raster order; in_tuser marks the
//           first pixel of a frame and puts it at row 0, column 0
//   out_* : one item per input item, in order; luma passes through, and on
//           odd rows at odd columns out_tuser is high with the rounded 2x2
//           means of cb and cr, otherwise both means read as zero
//   cfg_* : line width, written while no item is in flight; low bit ignored
// path: an accepted item is held in the front end's stage register, then in
//   the output register that drives out_*
// throughput: one item per cycle while out_tready is high; the line store
//   takes one write (even row) or one read (odd row) at each odd column, and its
//   registered read sets the second stage
// reset: position and line width return to row 0, column 0 and 1920; the
//   line store is not cleared, so an odd row must follow its even row
// stall: the output register and the stage behind it hold while out_tready
//   is low; in_tready drops only when both are full
`default_nettype none
module chroma_444_to_420_box_downsampler import cds_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LW_BITS-1:0]    cfg_wr_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [TDATA_BITS-1:0] in_tdata,   // luma_in, cb_in, cr_in
  input  wire logic                  in_tuser,   // start_of_frame
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [TDATA_BITS-1:0]      out_tdata,  // luma_out, cb_avg, cr_avg
  output logic                       out_tuser   // chroma_valid
);

  logic                      stage_valid, stage_ready;
  cds_stage_t                stage;
  cds_line_cmd_t             line_cmd;
  logic [LINE_WORD_BITS-1:0] line_rdata;

  cds_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage),
    .line_cmd    (line_cmd)
  );

  // cb pair sum in the low half, cr in the high half
  cds_ram #(
    .WIDTH (LINE_WORD_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_cmd.we),
    .waddr (line_cmd.waddr),
    .wdata (line_cmd.wdata),
    .re    (line_cmd.re),
    .raddr (line_cmd.raddr),
    .rdata (line_rdata)
  );

  cds_avg u_avg (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage),
    .line_rdata  (line_rdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  a_line_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_cmd.we && line_cmd.re))
    else $error("line store written and read for the same item");

  a_read_only_for_emit: assert property (@(posedge clk) disable iff (!rst_n)
    line_cmd.re |=> stage_valid && stage.emit)
    else $error("line store read without a block to finish");

  a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid && stage_ready |=> out_tvalid && out_tuser == $past(stage.emit))
    else $error("stage item lost on its way to the output");

  a_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[TDATA_BITS-1:FIELD_BITS] == '0)
    else $error("chroma means not zero without chroma_valid");

endmodule
`default_nettype wire
